// ===== rtl/adts_frame_delimiter_core_macros.svh =====
// assertion macros for the adts frame delimiter
`ifndef ADTS_FRAME_DELIMITER_CORE_MACROS_SVH
`define ADTS_FRAME_DELIMITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ADFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADFD_ASSERT(lbl, prop, msg) \
  `ADFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ADFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ADFD_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/adtsfd_pkg.sv =====
// package with constants and types of the adts frame delimiter
package adtsfd_pkg;

  localparam int unsigned HeaderBytesDef = 7;
  localparam int unsigned OffsetBitsDef  = 24;

  localparam int unsigned OutOffW  = 24;
  localparam int unsigned LenW     = 13;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [7:0] SyncFirstRst  = 8'hFF;
  localparam logic [7:0] SyncMaskRst   = 8'hF0;
  localparam logic [7:0] SyncValueRst  = 8'hF0;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST = 2'd0,
    REG_SYNC_MASK  = 2'd1,
    REG_SYNC_VALUE = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;

  localparam logic KindFrame   = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [OutOffW-1:0]   start;
    logic [LenW-1:0]      length;
    logic [OutOffW-1:0]   cend;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/adts_frame_delimiter_core.sv =====
// Top level of the adts frame delimiter: header hunt, frame counting and result queue.
// Takes one stream byte per beat and can accept a byte in every cycle. Each byte is
// processed in the cycle it is accepted; its results (none, one or two) are written
// into a four-entry result queue and leave it one per output beat. The input is held
// off only while the queue has fewer than two free entries, so a byte is never
// accepted without room for both of its possible results.
// end_of_data travels as s_tlast and resets the scan after its summary result.
`include "adts_frame_delimiter_core_macros.svh"

module adts_frame_delimiter_core #(
  parameter int unsigned HEADER_BYTES = adtsfd_pkg::HeaderBytesDef,
  parameter int unsigned OFFSET_BITS  = adtsfd_pkg::OffsetBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adtsfd_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tlast,   // end_of_data
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,   // frame_start, frame_length, complete_end
  output logic                            m_tuser,   // result_kind
  output logic                            m_tlast    // last_of_run
);

  localparam int unsigned FillW = $clog2(HEADER_BYTES);
  localparam int unsigned LenW  = adtsfd_pkg::LenW;
  localparam int unsigned OutW  = adtsfd_pkg::OutOffW;
  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OffMax) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic logic [OutW-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OutW-1:0] ext;
    ext = (OFFSET_BITS + OutW)'(v);
    return ext[OutW-1:0];
  endfunction

  // configuration registers
  logic [7:0] sync_first_q, sync_mask_q, sync_value_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q <= adtsfd_pkg::SyncFirstRst;
      sync_mask_q  <= adtsfd_pkg::SyncMaskRst;
      sync_value_q <= adtsfd_pkg::SyncValueRst;
    end else if (cfg_wr) begin
      unique case (adtsfd_pkg::reg_idx_e'(paddr[3:2]))
        adtsfd_pkg::REG_SYNC_FIRST: sync_first_q <= pwdata[7:0];
        adtsfd_pkg::REG_SYNC_MASK:  sync_mask_q  <= pwdata[7:0];
        adtsfd_pkg::REG_SYNC_VALUE: sync_value_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (adtsfd_pkg::reg_idx_e'(paddr[3:2]))
      adtsfd_pkg::REG_SYNC_FIRST: prdata = {24'b0, sync_first_q};
      adtsfd_pkg::REG_SYNC_MASK:  prdata = {24'b0, sync_mask_q};
      adtsfd_pkg::REG_SYNC_VALUE: prdata = {24'b0, sync_value_q};
      default:                    prdata = 32'b0;
    endcase
  end

  // scan state
  logic [7:0]             win_q [HEADER_BYTES];
  logic [7:0]             win_n [HEADER_BYTES];
  logic [7:0]             win_d [HEADER_BYTES];
  logic [FillW-1:0]       fill_q, fill_d;
  logic                   in_frame_q, in_frame_d;
  logic [LenW-1:0]        bytes_left_q, bytes_left_d;
  logic [LenW-1:0]        frame_len_q, frame_len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] cur_start_q, cur_start_d;
  logic [OFFSET_BITS-1:0] lce_q, lce_d;

  logic                   s_acc, eod, done;
  logic [LenW-1:0]        hdr_len;
  logic                   hdr_sync;
  logic [LenW-1:0]        left_dec;
  logic [OFFSET_BITS-1:0] cs_sel;
  adtsfd_pkg::res_t       res_frame, res_sum, push_a, push_b;
  logic [1:0]             push_n;

  assign s_acc = s_tvalid & s_tready;
  assign eod   = s_tlast;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      win_n[i] = (fill_q == FillW'(i)) ? s_tdata : win_q[i];
    end
  end

  assign hdr_len  = {win_n[3][1:0], 11'b0} | {2'b0, win_n[4], 3'b0} | {10'b0, win_n[5][7:5]};
  assign hdr_sync = (win_n[0] == sync_first_q) && ((win_n[1] & sync_mask_q) == sync_value_q);
  assign left_dec = (bytes_left_q != '0) ? bytes_left_q - LenW'(1) : bytes_left_q;
  assign cs_sel   = (fill_q == '0) ? pos_q : cur_start_q;

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    frame_len_d  = frame_len_q;
    pos_d        = pos_q;
    cur_start_d  = cur_start_q;
    lce_d        = lce_q;
    done         = 1'b0;
    if (s_acc) begin
      pos_d = sat_inc(pos_q);
      if (in_frame_q) begin
        bytes_left_d = left_dec;
        done         = (left_dec == '0);
      end else begin
        cur_start_d = cs_sel;
        win_d       = win_n;
        if (fill_q == FillW'(HEADER_BYTES - 1)) begin
          if (hdr_sync && (hdr_len >= LenW'(HEADER_BYTES))) begin
            in_frame_d   = 1'b1;
            frame_len_d  = hdr_len;
            bytes_left_d = hdr_len - LenW'(HEADER_BYTES);
            fill_d       = '0;
            done         = (hdr_len == LenW'(HEADER_BYTES));
          end else begin
            for (int i = 0; i < HEADER_BYTES - 1; i++) begin
              win_d[i] = win_n[i+1];
            end
            fill_d      = FillW'(HEADER_BYTES - 1);
            cur_start_d = sat_inc(cs_sel);
          end
        end else begin
          fill_d = fill_q + FillW'(1);
        end
      end
      if (done) begin
        lce_d        = sat_inc(pos_q);
        in_frame_d   = 1'b0;
        bytes_left_d = '0;
        fill_d       = '0;
      end
      if (eod) begin
        fill_d       = '0;
        in_frame_d   = 1'b0;
        bytes_left_d = '0;
        pos_d        = '0;
        cur_start_d  = '0;
        lce_d        = '0;
        frame_len_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
      frame_len_q  <= '0;
      pos_q        <= '0;
      cur_start_q  <= '0;
      lce_q        <= '0;
    end else begin
      fill_q       <= fill_d;
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
      frame_len_q  <= frame_len_d;
      pos_q        <= pos_d;
      cur_start_q  <= cur_start_d;
      lce_q        <= lce_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // results of the accepted byte
  always_comb begin
    res_frame.kind   = adtsfd_pkg::KindFrame;
    res_frame.start  = to_out(cur_start_d);
    res_frame.length = frame_len_d;
    res_frame.cend   = to_out(sat_inc(pos_q));
    res_frame.last   = ~eod;
    if (eod) begin
      res_frame.start  = to_out(in_frame_q ? cur_start_q : cs_sel);
      res_frame.length = in_frame_q ? frame_len_q : hdr_len;
    end
    res_sum.kind   = adtsfd_pkg::KindSummary;
    res_sum.start  = '0;
    res_sum.length = '0;
    res_sum.cend   = to_out(done ? sat_inc(pos_q) : lce_q);
    res_sum.last   = 1'b1;
  end

  assign push_a = done ? res_frame : res_sum;
  assign push_b = res_sum;
  assign push_n = s_acc ? ({1'b0, done} + {1'b0, eod}) : 2'd0;

  // result queue
  adtsfd_pkg::res_t                q_mem [adtsfd_pkg::QDepth];
  logic [adtsfd_pkg::QPtrW-1:0]    head_q, tail_q;
  logic [adtsfd_pkg::QCntW-1:0]    cnt_q;
  logic                            pop;

  assign m_tvalid = (cnt_q != '0);
  assign pop      = m_tvalid & m_tready;
  assign s_tready = (cnt_q <= adtsfd_pkg::QCntW'(adtsfd_pkg::QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_q + adtsfd_pkg::QPtrW'(pop);
      tail_q <= tail_q + adtsfd_pkg::QPtrW'(push_n);
      cnt_q  <= cnt_q + adtsfd_pkg::QCntW'(push_n) - adtsfd_pkg::QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[tail_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      q_mem[tail_q + adtsfd_pkg::QPtrW'(1)] <= push_b;
    end
  end

  adtsfd_pkg::res_t q_head;
  assign q_head  = q_mem[head_q];
  assign m_tdata = {3'b0, q_head.cend, q_head.length, q_head.start};
  assign m_tuser = q_head.kind;
  assign m_tlast = q_head.last;

  `ADFD_ASSERT(a_queue_bound, cnt_q <= adtsfd_pkg::QCntW'(adtsfd_pkg::QDepth),
               "result queue overfilled")
  `ADFD_ASSERT(a_fill_bound, fill_q <= FillW'(HEADER_BYTES - 1), "header window overfilled")
  `ADFD_ASSERT(a_eod_clears,
               s_acc && s_tlast |=> pos_q == '0 && !in_frame_q && lce_q == '0,
               "scan not cleared after end of data")
  `ADFD_ASSERT(a_mid_frame_quiet,
               s_acc && in_frame_q && bytes_left_q > LenW'(1) && !s_tlast |-> push_n == 2'd0,
               "result inside a frame body")

endmodule
